// File: hdl/shrb_pkg.sv
// ----------------------------------------------------------------------------
// shrb_pkg
// shared types and constants for the sample history ring buffer
// ----------------------------------------------------------------------------
package shrb_pkg;

  localparam int unsigned DEPTH_DEFAULT    = 1024;
  localparam int unsigned MAX_READ_DEFAULT = 64;
  localparam int unsigned SAMPLE_W         = 32;
  localparam int unsigned COUNT_W          = 7;
  localparam int unsigned TOTAL_W          = 64;
  // queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH      = 4;

  // request command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_REJECT
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [SAMPLE_W-1:0] sample;
    logic [COUNT_W-1:0]  count;
  } item_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                ok;
    logic [TOTAL_W-1:0]  total;
  } result_t;

endpackage

// File: hdl/sample_history_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// sample_history_ring_buffer_top
// throughput: one write per cycle while the request channel is not stalled;
//   the read sequencer issues one result slot per cycle while the result
//   buffer has room, stepping one store address per slot once the zero
//   padding is done
// reset: synchronous, clears the write total, queue and result buffer; the
//   sample store is not cleared, entries are only read once written
// ----------------------------------------------------------------------------
module sample_history_ring_buffer_top #(
  parameter int unsigned DEPTH    = shrb_pkg::DEPTH_DEFAULT,
  parameter int unsigned MAX_READ = shrb_pkg::MAX_READ_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          cmd,
  input  logic [shrb_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [shrb_pkg::COUNT_W-1:0]  read_count,
  // result channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [shrb_pkg::SAMPLE_W-1:0] sample_out,
  output logic                          last,
  output logic                          ok,
  output logic [shrb_pkg::TOTAL_W-1:0]  total_written
);

  // front to queue
  logic            front_valid;
  logic            front_stall;
  shrb_pkg::item_t front_item;

  // queue to back
  logic            q_valid;
  logic            q_pop;
  shrb_pkg::item_t q_item;

  // front: takes one request transaction per cycle while it is not stalled and tags it as a write,
  // a read or a rejected read count
  shrb_front #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .sample_in  (sample_in),
    .read_count (read_count),
    .item_valid (front_valid),
    .item_stall (front_stall),
    .item       (front_item)
  );

  // short queue lets writes keep arriving while a read run streams out
  shrb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // back: applies writes to the store in order and sequences read runs,
  // padding with zeros where the history is shorter than the count
  shrb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .sample_out    (sample_out),
    .last          (last),
    .ok            (ok),
    .total_written (total_written)
  );

  // a rejected count always gives a single zero result that closes the run
  a_reject_form : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !ok) |-> (last && sample_out == '0))
    else $error("rejected result not a single zero transaction");

  // only a valid read produces more than one result
  a_run_ok : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !last) |-> ok)
    else $error("non-final result without ok");

  // the front only pushes back while it is holding an item
  a_front_stall : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> front_valid)
    else $error("request stalled with empty front stage");

  // the back never takes from an empty queue
  a_queue_pop : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// File: hdl/shrb_front.sv
// ----------------------------------------------------------------------------
// shrb_front
// accepts request transactions and classifies them as write, read or reject
// ----------------------------------------------------------------------------
module shrb_front #(
  parameter int unsigned DEPTH    = shrb_pkg::DEPTH_DEFAULT,
  parameter int unsigned MAX_READ = shrb_pkg::MAX_READ_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          cmd,
  input  logic [shrb_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [shrb_pkg::COUNT_W-1:0]  read_count,
  output logic                          item_valid,
  input  logic                          item_stall,
  output shrb_pkg::item_t               item
);

  shrb_pkg::item_t item_next;
  logic            load;
  logic            bad_count;

  assign req_stall = item_valid && item_stall;
  assign load      = req_valid && !req_stall;

  // count of zero, or beyond the store or the read limit
  assign bad_count = (read_count == '0)
                  || (32'(read_count) > 32'(DEPTH))
                  || (32'(read_count) > 32'(MAX_READ));

  always_comb begin
    item_next.sample = sample_in;
    item_next.count  = read_count;
    if (cmd == shrb_pkg::CMD_WRITE) begin
      item_next.kind = shrb_pkg::KIND_WRITE;
    end else if (bad_count) begin
      item_next.kind = shrb_pkg::KIND_REJECT;
    end else begin
      item_next.kind = shrb_pkg::KIND_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (!item_stall) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

// File: hdl/shrb_queue.sv
// ----------------------------------------------------------------------------
// shrb_queue
// short first-in first-out queue of classified items
// ----------------------------------------------------------------------------
module shrb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_stall,
  input  shrb_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop,
  output shrb_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = $clog2(shrb_pkg::QUEUE_DEPTH);

  shrb_pkg::item_t    entries [shrb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     fill;
  logic               do_push;
  logic               do_pop;

  assign push_stall = (fill == (PTR_W+1)'(shrb_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// File: hdl/shrb_back.sv
// ----------------------------------------------------------------------------
// shrb_back
// executes items in order: sample store, write total, read sequencer and
// a two-entry result buffer
// ----------------------------------------------------------------------------
module shrb_back #(
  parameter int unsigned DEPTH = shrb_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  shrb_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [shrb_pkg::SAMPLE_W-1:0] sample_out,
  output logic                          last,
  output logic                          ok,
  output logic [shrb_pkg::TOTAL_W-1:0]  total_written
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CW     = shrb_pkg::COUNT_W;
  localparam int unsigned TW     = shrb_pkg::TOTAL_W;
  localparam int unsigned SW     = shrb_pkg::SAMPLE_W;

  logic [SW-1:0]          mem [DEPTH];
  logic [SW-1:0]          mem_q;

  shrb_pkg::back_state_t  state;
  shrb_pkg::back_state_t  state_next;
  logic [CW-1:0]          remaining;
  logic [CW-1:0]          pad_left;
  logic [ADDR_W-1:0]      rd_addr;
  logic [TW-1:0]          write_total;

  // issue stage, memory data lands alongside
  logic                   a_valid;
  logic                   a_zero;
  logic                   a_last;
  logic                   a_ok;
  logic [TW-1:0]          a_total;

  // result buffer
  shrb_pkg::result_t      ob [2];
  shrb_pkg::result_t      ob_in;
  logic                   ob_wr;
  logic                   ob_rd;
  logic [1:0]             ob_cnt;
  logic                   ob_pop;

  logic                   room;
  logic                   do_write;
  logic                   load_run;
  logic                   issue;
  logic                   issue_zero;
  logic                   issue_last;
  logic                   issue_ok;

  logic                   short_hist;
  logic [CW-1:0]          pad_init;
  logic [TW-1:0]          pos_full;
  logic [ADDR_W-1:0]      addr_init;

  assign ob_pop = (ob_cnt != '0) && !rsp_stall;
  // a slot may issue if buffer plus slot in flight leaves an entry free
  assign room   = ({1'b0, ob_cnt} + {2'b00, a_valid}) < (3'd2 + {2'b00, ob_pop});

  assign short_hist = (write_total[TW-1:CW] == '0) && (write_total[CW-1:0] < q_item.count);
  assign pad_init   = short_hist ? (q_item.count - write_total[CW-1:0]) : '0;
  assign pos_full   = write_total - TW'(q_item.count);
  assign addr_init  = short_hist ? '0 : pos_full[ADDR_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      shrb_pkg::BACK_IDLE: begin
        if (q_valid && q_item.kind == shrb_pkg::KIND_READ) begin
          state_next = shrb_pkg::BACK_RUN;
        end
      end
      shrb_pkg::BACK_RUN: begin
        if (room && remaining == CW'(1)) begin
          state_next = shrb_pkg::BACK_IDLE;
        end
      end
      default: state_next = shrb_pkg::BACK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    do_write   = 1'b0;
    load_run   = 1'b0;
    issue      = 1'b0;
    issue_zero = 1'b0;
    issue_last = 1'b0;
    issue_ok   = 1'b0;
    unique case (state)
      shrb_pkg::BACK_IDLE: begin
        if (q_valid) begin
          unique case (q_item.kind)
            shrb_pkg::KIND_WRITE: begin
              q_pop    = 1'b1;
              do_write = 1'b1;
            end
            shrb_pkg::KIND_READ: begin
              q_pop    = 1'b1;
              load_run = 1'b1;
            end
            shrb_pkg::KIND_REJECT: begin
              if (room) begin
                q_pop      = 1'b1;
                issue      = 1'b1;
                issue_zero = 1'b1;
                issue_last = 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      shrb_pkg::BACK_RUN: begin
        if (room) begin
          issue      = 1'b1;
          issue_zero = (pad_left != '0);
          issue_last = (remaining == CW'(1));
          issue_ok   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= shrb_pkg::BACK_IDLE;
      write_total <= '0;
      remaining   <= '0;
      a_valid     <= 1'b0;
    end else begin
      state   <= state_next;
      a_valid <= issue;
      if (do_write) begin
        write_total <= write_total + 1'b1;
      end
      if (load_run) begin
        remaining <= q_item.count;
      end else if (issue && state == shrb_pkg::BACK_RUN) begin
        remaining <= remaining - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_run) begin
      pad_left <= pad_init;
      rd_addr  <= addr_init;
    end else if (issue && state == shrb_pkg::BACK_RUN) begin
      if (pad_left != '0) begin
        pad_left <= pad_left - 1'b1;
      end else begin
        rd_addr <= rd_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_zero  <= issue_zero;
    a_last  <= issue_last;
    a_ok    <= issue_ok;
    a_total <= write_total;
  end

  // sample store
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[write_total[ADDR_W-1:0]] <= q_item.sample;
    end
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    ob_in.sample = a_zero ? '0 : mem_q;
    ob_in.last   = a_last;
    ob_in.ok     = a_ok;
    ob_in.total  = a_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= 1'b0;
      ob_rd  <= 1'b0;
      ob_cnt <= '0;
    end else begin
      if (a_valid) begin
        ob_wr <= !ob_wr;
      end
      if (ob_pop) begin
        ob_rd <= !ob_rd;
      end
      if (a_valid && !ob_pop) begin
        ob_cnt <= ob_cnt + 1'b1;
      end else if (ob_pop && !a_valid) begin
        ob_cnt <= ob_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      ob[ob_wr] <= ob_in;
    end
  end

  assign rsp_valid     = (ob_cnt != '0);
  assign sample_out    = ob[ob_rd].sample;
  assign last          = ob[ob_rd].last;
  assign ok            = ob[ob_rd].ok;
  assign total_written = ob[ob_rd].total;

endmodule

// File: tb/tb_sample_history_ring_buffer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_history_ring_buffer_top
// self-checking bench for the sample history ring buffer: a short directed
// table, then random write/read traffic with idling on both channels, a long
// receiver hold-off and a burst with no idling; every result transaction is
// checked against a pinned expectation or a local history model
// ----------------------------------------------------------------------------
module tb_sample_history_ring_buffer_top;

  localparam int unsigned HISTORY_DEPTH  = shrb_pkg::DEPTH_DEFAULT;
  localparam int unsigned MAX_READ_LEN   = shrb_pkg::MAX_READ_DEFAULT;
  localparam int unsigned CNT_W          = shrb_pkg::COUNT_W;
  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned IDLE_PERCENT   = 28;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned MIXED_ITEMS    = 120;
  localparam int unsigned PRESSURE_ITEMS = 60;
  localparam int unsigned BURST_ITEMS    = 200;

  // request command codes
  localparam logic CMD_WRITE = shrb_pkg::CMD_WRITE;
  localparam logic CMD_READ  = shrb_pkg::CMD_READ;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  logic                          cmd = CMD_WRITE;
  logic [shrb_pkg::SAMPLE_W-1:0] sample_in = '0;
  logic [shrb_pkg::COUNT_W-1:0]  read_count = '0;
  logic                          rsp_valid;
  logic                          rsp_stall = 1'b0;
  logic [shrb_pkg::SAMPLE_W-1:0] sample_out;
  logic                          last;
  logic                          ok;
  logic [shrb_pkg::TOTAL_W-1:0]  total_written;

  sample_history_ring_buffer_top #(
    .DEPTH    (HISTORY_DEPTH),
    .MAX_READ (MAX_READ_LEN)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .cmd           (cmd),
    .sample_in     (sample_in),
    .read_count    (read_count),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .sample_out    (sample_out),
    .last          (last),
    .ok            (ok),
    .total_written (total_written)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // history model: own copy of the sample store and the running total
  // ---------------------------------------------------------------------------
  logic [shrb_pkg::SAMPLE_W-1:0] sample_history [HISTORY_DEPTH];
  logic [shrb_pkg::TOTAL_W-1:0]  history_total = '0;
  shrb_pkg::result_t             pending_samples [$];

  // traffic shaping knobs, changed with nonblocking assignments only
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  int unsigned writes_sent    = 0;
  int unsigned reads_sent     = 0;
  int unsigned rejects_seen   = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  // a write stores at the running total modulo the depth and bumps the total;
  // a read of a legal count returns the newest words oldest first, with
  // leading zeros when the history is shorter than the count; a count of
  // zero or beyond the limits gives a single rejected result
  task automatic predict_request(input logic op,
                                 input logic [shrb_pkg::SAMPLE_W-1:0] word,
                                 input logic [shrb_pkg::COUNT_W-1:0] n);
    shrb_pkg::result_t            r;
    logic [shrb_pkg::TOTAL_W-1:0] pos;
    int unsigned                  pad;
    if (op == CMD_WRITE) begin
      sample_history[history_total % HISTORY_DEPTH] = word;
      history_total = history_total + 64'd1;
    end else if (n == 0 || n > MAX_READ_LEN || n > HISTORY_DEPTH) begin
      r.sample = '0;
      r.last   = 1'b1;
      r.ok     = 1'b0;
      r.total  = history_total;
      pending_samples.push_back(r);
    end else begin
      // short history pads the front of the run with zeros
      pad = (history_total < n) ? int'(n - history_total) : 0;
      pos = (history_total < n) ? '0 : history_total - n;
      for (int k = 0; k < n; k++) begin
        r.sample = '0;
        if (k >= pad) begin
          r.sample = sample_history[pos % HISTORY_DEPTH];
          pos      = pos + 64'd1;
        end
        r.last  = (k == n - 1);
        r.ok    = 1'b1;
        r.total = history_total;
        pending_samples.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // request side: optional idle cycles, then hold the transaction until taken
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic op,
                              input logic [shrb_pkg::SAMPLE_W-1:0] word,
                              input logic [shrb_pkg::COUNT_W-1:0] n);
    while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    cmd        <= op;
    sample_in  <= word;
    read_count <= n;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    if (op == CMD_WRITE) writes_sent++;
    else reads_sent++;
  endtask

  // mostly writes and legal reads, short counts favoured, some rejects;
  // fields the command ignores still carry random bits
  task automatic send_random_request();
    logic                          op;
    logic [shrb_pkg::SAMPLE_W-1:0] word;
    logic [shrb_pkg::COUNT_W-1:0]  n;
    int unsigned                   pick;
    pick = $urandom_range(99);
    word = $urandom;
    n    = CNT_W'($urandom_range(127));
    op   = CMD_READ;
    if (pick < 60) begin
      op = CMD_WRITE;
      case ($urandom_range(9))
        0:       word = '0;
        1:       word = '1;
        default: ;
      endcase
    end else if (pick < 92) begin
      case ($urandom_range(9))
        0:          n = CNT_W'(MAX_READ_LEN);
        1, 2:       n = CNT_W'($urandom_range(MAX_READ_LEN, 17));
        default:    n = CNT_W'($urandom_range(16, 1));
      endcase
    end else begin
      n = $urandom_range(1) ? '0 : CNT_W'($urandom_range(127, MAX_READ_LEN + 1));
    end
    send_request(op, word, n);
    predict_request(op, word, n);
  endtask

  // ---------------------------------------------------------------------------
  // directed table: pinned rows carry a result readable at a glance (rejects,
  // single-word reads), the rest go through the history model
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic                          op;
    logic [shrb_pkg::SAMPLE_W-1:0] word;
    logic [shrb_pkg::COUNT_W-1:0]  n;
    logic                          pinned;
    logic [shrb_pkg::SAMPLE_W-1:0] exp_sample;
    logic                          exp_ok;
    logic [shrb_pkg::TOTAL_W-1:0]  exp_total;
  } stim_row_t;

  stim_row_t directed_rows [21] = '{
    // rejects and padding with an empty history
    '{CMD_READ,  32'h0000_0000, 7'd0,   1'b1, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_READ,  32'h0000_0000, 7'd65,  1'b1, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_READ,  32'hFFFF_FFFF, 7'd127, 1'b1, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_READ,  32'h0000_0000, 7'd1,   1'b1, 32'h0000_0000, 1'b1, 64'd0},
    '{CMD_READ,  32'h0000_0000, 7'd64,  1'b0, 32'h0000_0000, 1'b0, 64'd0},
    // extreme sample words, count field ignored on write
    '{CMD_WRITE, 32'h0000_0000, 7'd0,   1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_WRITE, 32'hFFFF_FFFF, 7'd127, 1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_WRITE, 32'hA5A5_A5A5, 7'd0,   1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_WRITE, 32'h5A5A_5A5A, 7'd0,   1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_READ,  32'h0000_0000, 7'd1,   1'b1, 32'h5A5A_5A5A, 1'b1, 64'd4},
    '{CMD_READ,  32'h0000_0000, 7'd4,   1'b0, 32'h0000_0000, 1'b0, 64'd0},
    // short history: leading zeros
    '{CMD_READ,  32'h0000_0000, 7'd6,   1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_READ,  32'h0000_0000, 7'd64,  1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_WRITE, 32'h8000_0000, 7'd0,   1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_WRITE, 32'h0000_0001, 7'd0,   1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_WRITE, 32'h7FFF_FFFF, 7'd0,   1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_READ,  32'h0000_0000, 7'd2,   1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_READ,  32'h0000_0000, 7'd0,   1'b1, 32'h0000_0000, 1'b0, 64'd7},
    '{CMD_READ,  32'h0000_0000, 7'd96,  1'b1, 32'h0000_0000, 1'b0, 64'd7},
    '{CMD_WRITE, 32'h1234_5678, 7'd127, 1'b0, 32'h0000_0000, 1'b0, 64'd0},
    '{CMD_READ,  32'hFFFF_FFFF, 7'd8,   1'b0, 32'h0000_0000, 1'b0, 64'd0}
  };

  // ---------------------------------------------------------------------------
  // result side: check on acceptance, then choose the next stall value
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      results_seen++;
      if (ok === 1'b0) rejects_seen++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result transaction: sample %h last %b ok %b total %0d",
                   $time, sample_out, last, ok, total_written);
      end else begin
        automatic shrb_pkg::result_t e = pending_samples.pop_front();
        if (sample_out !== e.sample || last !== e.last || ok !== e.ok ||
            total_written !== e.total) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch exp/act sample %h/%h last %b/%b ok %b/%b total %0d/%0d",
                     $time, e.sample, sample_out, e.last, last, e.ok, ok,
                     e.total, total_written);
        end
      end
    end

    // long hold-off when asked, otherwise random idling unless switched off
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      rsp_stall   <= 1'b1;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES - 1;
    end else begin
      rsp_stall <= receiver_idles && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((req_valid === 1'b1 && req_stall === 1'b0) ||
        (rsp_valid === 1'b1 && rsp_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_samples.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].word, directed_rows[i].n);
      if (directed_rows[i].pinned)
        pending_samples.push_back(shrb_pkg::result_t'({directed_rows[i].exp_sample, 1'b1,
                                                       directed_rows[i].exp_ok,
                                                       directed_rows[i].exp_total}));
      else
        predict_request(directed_rows[i].op, directed_rows[i].word, directed_rows[i].n);
    end

    // mixed random traffic with idling on both sides
    repeat (MIXED_ITEMS) send_random_request();

    // receiver holds off while the sender keeps offering, so the block backs up
    sender_idles <= 1'b0;
    hold_asked   <= hold_asked + 1;
    repeat (PRESSURE_ITEMS) send_random_request();

    // long stretch with no idling on either side: mostly writes, with the
    // odd read of the newest samples
    receiver_idles <= 1'b0;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      automatic logic [shrb_pkg::SAMPLE_W-1:0] word = $urandom;
      automatic logic [shrb_pkg::COUNT_W-1:0]  n    =
        CNT_W'($urandom_range(MAX_READ_LEN, 1));
      automatic logic                          op   = (i % 97 == 96) ? CMD_READ : CMD_WRITE;
      send_request(op, word, n);
      predict_request(op, word, n);
    end
    sender_idles   <= 1'b1;
    receiver_idles <= 1'b1;

    // more mixed traffic on a fuller history
    repeat (MIXED_ITEMS) send_random_request();
    req_valid <= 1'b0;

    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d writes and %0d reads (%0d rejected), %0d samples held in total",
             writes_sent, reads_sent, rejects_seen, history_total);
    $display("%0d result transactions checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
